// ===== hw/rtl/kdac_pkg.sv =====
// Package for the keypad door access controller.
// Holds mode, event and key codes, register indexes and reset values, and the lamp struct.
// No dependencies; compile first.
`timescale 1ns / 1ps

package kdac_pkg;

  typedef enum logic [6:0] {
    MODE_NORMAL   = 7'b0000001,
    MODE_REQUEST  = 7'b0000010,
    MODE_LOCK     = 7'b0000100,
    MODE_UNLOCK   = 7'b0001000,
    MODE_EMG_WAIT = 7'b0010000,
    MODE_EMG_OPEN = 7'b0100000,
    MODE_NO_INIT  = 7'b1000000
  } mode_t;

  localparam logic [2:0] MODE_CODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_CODE_REQUEST  = 3'd1;
  localparam logic [2:0] MODE_CODE_LOCK     = 3'd2;
  localparam logic [2:0] MODE_CODE_UNLOCK   = 3'd3;
  localparam logic [2:0] MODE_CODE_EMG_WAIT = 3'd4;
  localparam logic [2:0] MODE_CODE_EMG_OPEN = 3'd5;
  localparam logic [2:0] MODE_CODE_NO_INIT  = 3'd6;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_KEY    = 2'd1;
  localparam logic [1:0] FUNC_UNLOCK = 2'd2;
  localparam logic [1:0] FUNC_LOCK   = 2'd3;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SECS_W      = 6;
  localparam int HUND_OUT_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACCESS_CODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_ARMED     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRICT_MODE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_SECS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_SECS      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNLOCK_SECS    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_EMG_WAIT_SECS  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_EMG_OPEN_SECS  = 3'd7;

  localparam logic [SECS_W-1:0] RST_REQUEST_SECS  = 6'd3;
  localparam logic [SECS_W-1:0] RST_LOCK_SECS     = 6'd15;
  localparam logic [SECS_W-1:0] RST_UNLOCK_SECS   = 6'd5;
  localparam logic [SECS_W-1:0] RST_EMG_WAIT_SECS = 6'd30;
  localparam logic [SECS_W-1:0] RST_EMG_OPEN_SECS = 6'd15;

  localparam logic [3:0] RST_DIGIT = 4'd1;
  localparam int BUZZ_LIMIT = 50;

  typedef struct packed {
    logic open;
    logic fail;
    logic allow;
    logic denied;
    logic locked;
    logic unlocked;
    logic buzz;
  } lamps_t;

endpackage

// ===== hw/rtl/kdac_item_if.sv =====
// Input channel of the keypad door access controller: one event per beat.
// Uses no package.
`timescale 1ns / 1ps

interface kdac_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink (input valid, input func, input key_code, output ready);
endinterface

// ===== hw/rtl/kdac_result_if.sv =====
// Result channel of the keypad door access controller: mode, lamps and countdown per beat.
// Uses no package.
`timescale 1ns / 1ps

interface kdac_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       lamp_open;
  logic       lamp_fail;
  logic       lamp_allow;
  logic       lamp_denied;
  logic       lamp_locked;
  logic       lamp_unlocked;
  logic       buzz;
  logic [5:0] seconds_left;
  logic [6:0] hundredths_left;

  modport source (
    output valid, output mode, output lamp_open, output lamp_fail, output lamp_allow,
    output lamp_denied, output lamp_locked, output lamp_unlocked, output buzz,
    output seconds_left, output hundredths_left, input ready
  );
  modport sink (
    input valid, input mode, input lamp_open, input lamp_fail, input lamp_allow,
    input lamp_denied, input lamp_locked, input lamp_unlocked, input buzz,
    input seconds_left, input hundredths_left, output ready
  );
endinterface

// ===== hw/rtl/kdac_lamp_decode.sv =====
// Lamp, buzzer and mode code decode for the keypad door access controller.
// Depends on kdac_pkg.
`timescale 1ns / 1ps

module kdac_lamp_decode import kdac_pkg::*; (
  input  mode_t        mode,
  input  logic         below_half,
  input  logic         phase,
  output logic [2:0]   mode_code,
  output lamps_t       lamps
);

  always_comb begin
    lamps = '0;
    mode_code = MODE_CODE_NO_INIT;
    unique case (mode)
      MODE_NORMAL: begin
        mode_code = MODE_CODE_NORMAL;
        lamps.locked = 1'b1;
      end
      MODE_REQUEST: begin
        mode_code = MODE_CODE_REQUEST;
        lamps.locked = 1'b1;
        lamps.buzz = below_half;
      end
      MODE_LOCK: begin
        mode_code = MODE_CODE_LOCK;
        lamps.denied = 1'b1;
        lamps.locked = 1'b1;
      end
      MODE_UNLOCK: begin
        mode_code = MODE_CODE_UNLOCK;
        lamps.open = 1'b1;
        lamps.allow = 1'b1;
        lamps.unlocked = 1'b1;
      end
      MODE_EMG_WAIT: begin
        mode_code = MODE_CODE_EMG_WAIT;
        lamps.buzz = phase;
        lamps.open = phase;
        lamps.allow = phase;
        lamps.locked = 1'b1;
      end
      MODE_EMG_OPEN: begin
        mode_code = MODE_CODE_EMG_OPEN;
        lamps.open = 1'b1;
        lamps.fail = 1'b1;
        lamps.allow = 1'b1;
        lamps.unlocked = 1'b1;
      end
      default: begin
        mode_code = MODE_CODE_NO_INIT;
        lamps.open = 1'b1;
        lamps.unlocked = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/keypad_door_access_controller_unit.sv =====
// Top level of the keypad door access controller.
// Depends on kdac_pkg, kdac_item_if, kdac_result_if and kdac_lamp_decode.
`timescale 1ns / 1ps

// The block takes one event beat per clock cycle (tick, keypad key, unlock or lock
// button) while its results are taken, and returns exactly one result beat for it,
// registered in the cycle after the event is accepted. The whole update of mode,
// countdown and code entry is one pass of logic between the state registers and the
// result register, so the sustained rate is one beat per cycle; an event is taken
// while the previous result still waits, as long as that result is taken in the same
// cycle. The hundredths count is kept next to a decimal tens and units copy so that the
// emergency wait blink needs no divider. Write configuration registers through the
// plain write port only while no beat is in flight; the block does not enforce this.
module keypad_door_access_controller_unit import kdac_pkg::*; #(
  parameter int CODE_LENGTH      = 4,
  parameter int TICKS_PER_SECOND = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  kdac_item_if.sink              item,
  kdac_result_if.source          result
);

  localparam int HW         = $clog2(TICKS_PER_SECOND);
  localparam int PW         = $clog2(CODE_LENGTH + 1);
  localparam int CW         = 4 * CODE_LENGTH;
  localparam int TENS_MAX   = (TICKS_PER_SECOND - 1) / 10;
  localparam int TW         = (TENS_MAX > 0) ? $clog2(TENS_MAX + 1) : 1;
  localparam logic [HW-1:0] HUND_RELOAD  = HW'(TICKS_PER_SECOND - 1);
  localparam logic [TW-1:0] TENS_RELOAD  = TW'(TENS_MAX);
  localparam logic [3:0]    UNITS_RELOAD = 4'((TICKS_PER_SECOND - 1) % 10);

  logic [CFG_DATA_W-1:0] access_code;
  logic                  code_armed;
  logic                  strict_mode;
  logic [SECS_W-1:0]     request_secs;
  logic [SECS_W-1:0]     lock_secs;
  logic [SECS_W-1:0]     unlock_secs;
  logic [SECS_W-1:0]     emg_wait_secs;
  logic [SECS_W-1:0]     emg_open_secs;

  mode_t             mode;
  mode_t             mode_next;
  mode_t             mode_evt;
  logic [SECS_W-1:0] secs;
  logic [SECS_W-1:0] secs_next;
  logic [SECS_W-1:0] secs_evt;
  logic [HW-1:0]     hund;
  logic [HW-1:0]     hund_next;
  logic [TW-1:0]     tens;
  logic [TW-1:0]     tens_next;
  logic [3:0]        units;
  logic [3:0]        units_next;
  logic [3:0]        digits [CODE_LENGTH];
  logic [3:0]        digits_next [CODE_LENGTH];
  logic [PW-1:0]     pos;
  logic [PW-1:0]     pos_next;

  logic [CW+15:0]    code_wide;
  logic [CW-1:0]     code_ext;
  logic              code_match;
  logic [PW:0]       pos_inc;
  logic              expired;
  logic [HW+6:0]     hund_wide;
  logic              below_half;
  logic [2:0]        mode_code;
  lamps_t            lamps;
  logic              accept;

  logic                  res_valid;
  logic [2:0]            res_mode;
  lamps_t                res_lamps;
  logic [SECS_W-1:0]     res_secs;
  logic [HUND_OUT_W-1:0] res_hund;

  assign accept     = item.valid && item.ready;
  assign item.ready = !res_valid || result.ready;

  assign code_wide = {{CW{1'b0}}, access_code};
  assign code_ext  = code_wide[CW-1:0];
  assign pos_inc   = {1'b0, pos} + (PW+1)'(1);

  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (digits[i] != code_ext[4*(CODE_LENGTH-1-i) +: 4]) begin
        code_match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_evt    = mode;
    secs_evt    = secs;
    hund_next   = hund;
    tens_next   = tens;
    units_next  = units;
    pos_next    = pos;
    digits_next = digits;
    unique case (item.func)
      FUNC_TICK: begin
        if (hund == '0 && secs != '0) begin
          secs_evt   = secs - SECS_W'(1);
          hund_next  = HUND_RELOAD;
          tens_next  = TENS_RELOAD;
          units_next = UNITS_RELOAD;
        end else if (hund != '0) begin
          hund_next = hund - HW'(1);
          if (units == 4'd0) begin
            units_next = 4'd9;
            tens_next  = tens - TW'(1);
          end else begin
            units_next = units - 4'd1;
          end
        end
      end
      FUNC_KEY: begin
        if (mode == MODE_NORMAL) begin
          priority if (item.key_code <= KEY_DIGIT_MAX) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
              if ({1'b0, pos} == (PW+1)'(i)) begin
                digits_next[i] = item.key_code;
              end
            end
            if (pos_inc == (PW+1)'(CODE_LENGTH + 1)) begin
              pos_next = '0;
            end else begin
              pos_next = pos_inc[PW-1:0];
            end
          end else if (item.key_code == KEY_STAR) begin
            pos_next = '0;
          end else if (item.key_code == KEY_HASH && !strict_mode) begin
            pos_next = '0;
            if (pos == PW'(CODE_LENGTH)) begin
              if (code_match) begin
                mode_evt = MODE_EMG_WAIT;
                secs_evt = emg_wait_secs;
              end
            end else begin
              mode_evt = MODE_REQUEST;
              secs_evt = request_secs;
            end
          end else begin
            pos_next = pos;
          end
        end
      end
      FUNC_UNLOCK: begin
        mode_evt = MODE_UNLOCK;
        secs_evt = unlock_secs;
      end
      FUNC_LOCK: begin
        mode_evt = MODE_LOCK;
        secs_evt = lock_secs;
      end
    endcase

    expired   = (secs_evt == '0) && (hund_next == '0);
    mode_next = mode_evt;
    secs_next = secs_evt;
    unique case (mode_evt)
      MODE_NORMAL: begin
        if (!code_armed) begin
          mode_next = MODE_NO_INIT;
        end
      end
      MODE_REQUEST, MODE_LOCK, MODE_UNLOCK, MODE_EMG_OPEN: begin
        if (expired) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_EMG_WAIT: begin
        if (expired) begin
          mode_next = MODE_EMG_OPEN;
          secs_next = emg_open_secs;
        end
      end
      default: begin
        mode_next = code_armed ? MODE_NORMAL : MODE_NO_INIT;
      end
    endcase
  end

  assign hund_wide  = {7'b0, hund_next};
  assign below_half = hund_wide < (HW+7)'(BUZZ_LIMIT);

  kdac_lamp_decode u_lamp_decode (
    .mode       (mode_next),
    .below_half (below_half),
    .phase      (tens_next[0]),
    .mode_code  (mode_code),
    .lamps      (lamps)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      access_code   <= '0;
      code_armed    <= 1'b0;
      strict_mode   <= 1'b0;
      request_secs  <= RST_REQUEST_SECS;
      lock_secs     <= RST_LOCK_SECS;
      unlock_secs   <= RST_UNLOCK_SECS;
      emg_wait_secs <= RST_EMG_WAIT_SECS;
      emg_open_secs <= RST_EMG_OPEN_SECS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ACCESS_CODE:   access_code   <= cfg_data;
        CFG_CODE_ARMED:    code_armed    <= cfg_data[0];
        CFG_STRICT_MODE:   strict_mode   <= cfg_data[0];
        CFG_REQUEST_SECS:  request_secs  <= cfg_data[SECS_W-1:0];
        CFG_LOCK_SECS:     lock_secs     <= cfg_data[SECS_W-1:0];
        CFG_UNLOCK_SECS:   unlock_secs   <= cfg_data[SECS_W-1:0];
        CFG_EMG_WAIT_SECS: emg_wait_secs <= cfg_data[SECS_W-1:0];
        CFG_EMG_OPEN_SECS: emg_open_secs <= cfg_data[SECS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_NORMAL;
      secs  <= '0;
      hund  <= '0;
      tens  <= '0;
      units <= '0;
      pos   <= '0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        digits[i] <= RST_DIGIT;
      end
    end else if (accept) begin
      mode   <= mode_next;
      secs   <= secs_next;
      hund   <= hund_next;
      tens   <= tens_next;
      units  <= units_next;
      pos    <= pos_next;
      digits <= digits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_mode  <= mode_code;
      res_lamps <= lamps;
      res_secs  <= secs_next;
      res_hund  <= hund_wide[HUND_OUT_W-1:0];
    end
  end

  assign result.valid           = res_valid;
  assign result.mode            = res_mode;
  assign result.lamp_open       = res_lamps.open;
  assign result.lamp_fail       = res_lamps.fail;
  assign result.lamp_allow      = res_lamps.allow;
  assign result.lamp_denied     = res_lamps.denied;
  assign result.lamp_locked     = res_lamps.locked;
  assign result.lamp_unlocked   = res_lamps.unlocked;
  assign result.buzz            = res_lamps.buzz;
  assign result.seconds_left    = res_secs;
  assign result.hundredths_left = res_hund;

endmodule

// ===== bench/keypad_door_access_controller_unit_tb.sv =====
// Testbench for keypad_door_access_controller_unit: a short table of events, then random
// phases of ticks, code entries and buttons, each beat checked by table or predictor.
// Depends on kdac_pkg, kdac_item_if, kdac_result_if and the RTL of the block.
`timescale 1ns / 1ps

module keypad_door_access_controller_unit_tb;
  import kdac_pkg::*;

  localparam int CODE_DIGITS = 4;
  localparam int TICKS_PER_SEC = 100;
  localparam int unsigned TOTAL_EVENTS = 1150;
  localparam int SCRIPT_LEN = 25;
  localparam int PHASE_B_ROW = 3;
  localparam int PHASE_C_ROW = 7;

  typedef struct packed {
    logic [2:0]            mode;
    lamps_t                lamps;
    logic [SECS_W-1:0]     secs;
    logic [HUND_OUT_W-1:0] hund;
  } door_status_t;

  typedef struct packed {
    logic [1:0]   func;
    logic [3:0]   key;
    logic         known;
    door_status_t want;
  } door_step_t;

  localparam lamps_t LAMPS_NORMAL   = 7'b0000100;
  localparam lamps_t LAMPS_NO_INIT  = 7'b1000010;
  localparam lamps_t LAMPS_LOCK     = 7'b0001100;
  localparam lamps_t LAMPS_EMG_OPEN = 7'b1110010;
  localparam lamps_t LAMPS_REQ_BUZZ = 7'b0000101;
  localparam door_status_t NOT_TYPED = '0;

  door_step_t script [SCRIPT_LEN] = '{
    {FUNC_TICK, 4'd0, 1'b1, MODE_CODE_NO_INIT, LAMPS_NO_INIT, 6'd0, 7'd0},
    {FUNC_KEY, 4'd9, 1'b1, MODE_CODE_NO_INIT, LAMPS_NO_INIT, 6'd0, 7'd0},
    {FUNC_LOCK, 4'd0, 1'b1, MODE_CODE_LOCK, LAMPS_LOCK, 6'd15, 7'd0},
    {FUNC_UNLOCK, 4'd0, 1'b1, MODE_CODE_NORMAL, LAMPS_NORMAL, 6'd0, 7'd0},
    {FUNC_KEY, 4'd0, 1'b0, NOT_TYPED},
    {FUNC_KEY, KEY_HASH, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd15, 1'b0, NOT_TYPED},
    {FUNC_KEY, KEY_STAR, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd0, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd0, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd0, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd0, 1'b0, NOT_TYPED},
    {FUNC_KEY, KEY_HASH, 1'b1, MODE_CODE_EMG_OPEN, LAMPS_EMG_OPEN, 6'd0, 7'd0},
    {FUNC_TICK, 4'd15, 1'b1, MODE_CODE_NORMAL, LAMPS_NORMAL, 6'd0, 7'd0},
    {FUNC_KEY, 4'd1, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd2, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd3, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd4, 1'b0, NOT_TYPED},
    {FUNC_KEY, KEY_HASH, 1'b1, MODE_CODE_NORMAL, LAMPS_NORMAL, 6'd0, 7'd0},
    {FUNC_KEY, 4'd1, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd2, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd3, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd4, 1'b0, NOT_TYPED},
    {FUNC_KEY, 4'd9, 1'b0, NOT_TYPED},
    {FUNC_KEY, KEY_HASH, 1'b1, MODE_CODE_REQUEST, LAMPS_REQ_BUZZ, 6'd63, 7'd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  kdac_item_if   event_ch();
  kdac_result_if status_ch();

  keypad_door_access_controller_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (event_ch),
    .result   (status_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [2:0]            door_mode;
  logic [SECS_W-1:0]     secs_left;
  logic [HUND_OUT_W-1:0] hund_left;
  logic [15:0]           entry_digits;
  logic [2:0]            entry_pos;

  logic [15:0]       code_reg;
  logic              armed_reg;
  logic              strict_reg;
  logic [SECS_W-1:0] request_reg;
  logic [SECS_W-1:0] lock_reg;
  logic [SECS_W-1:0] unlock_reg;
  logic [SECS_W-1:0] emg_wait_reg;
  logic [SECS_W-1:0] emg_open_reg;

  door_status_t pending_status [$];
  int unsigned  mismatches = 0;
  int unsigned  events_sent = 0;
  int unsigned  rx_hold = 0;
  bit           tx_gaps = 1'b1;
  bit           rx_gaps = 1'b1;

  function automatic door_status_t door_next_status(logic [1:0] f, logic [3:0] k);
    door_status_t s;
    logic         expired;
    logic [6:0]   tens;
    case (f)
      FUNC_TICK: begin
        if (hund_left == 0 && secs_left != 0) begin
          secs_left = secs_left - 1'b1;
          hund_left = HUND_OUT_W'(TICKS_PER_SEC - 1);
        end else if (hund_left != 0) begin
          hund_left = hund_left - 1'b1;
        end
      end
      FUNC_KEY: begin
        if (door_mode == MODE_CODE_NORMAL) begin
          if (k <= KEY_DIGIT_MAX) begin
            if (entry_pos < CODE_DIGITS)
              entry_digits[4*(CODE_DIGITS-1-int'(entry_pos)) +: 4] = k;
            entry_pos = (entry_pos == CODE_DIGITS) ? 3'd0 : entry_pos + 3'd1;
          end else if (k == KEY_STAR) begin
            entry_pos = 3'd0;
          end else if (k == KEY_HASH && !strict_reg) begin
            if (entry_pos != CODE_DIGITS) begin
              door_mode = MODE_CODE_REQUEST;
              secs_left = request_reg;
            end else if (entry_digits == code_reg) begin
              door_mode = MODE_CODE_EMG_WAIT;
              secs_left = emg_wait_reg;
            end
            entry_pos = 3'd0;
          end
        end
      end
      FUNC_UNLOCK: begin
        door_mode = MODE_CODE_UNLOCK;
        secs_left = unlock_reg;
      end
      default: begin
        door_mode = MODE_CODE_LOCK;
        secs_left = lock_reg;
      end
    endcase

    expired = (secs_left == 0 && hund_left == 0);
    case (door_mode)
      MODE_CODE_NORMAL: if (!armed_reg) door_mode = MODE_CODE_NO_INIT;
      MODE_CODE_REQUEST, MODE_CODE_LOCK, MODE_CODE_UNLOCK, MODE_CODE_EMG_OPEN: begin
        if (expired) door_mode = MODE_CODE_NORMAL;
      end
      MODE_CODE_EMG_WAIT: begin
        if (expired) begin
          door_mode = MODE_CODE_EMG_OPEN;
          secs_left = emg_open_reg;
        end
      end
      default: door_mode = armed_reg ? MODE_CODE_NORMAL : MODE_CODE_NO_INIT;
    endcase

    s = '0;
    s.mode = door_mode;
    s.secs = secs_left;
    s.hund = hund_left;
    case (door_mode)
      MODE_CODE_NORMAL: s.lamps.locked = 1'b1;
      MODE_CODE_REQUEST: begin
        s.lamps.locked = 1'b1;
        s.lamps.buzz = (hund_left < BUZZ_LIMIT);
      end
      MODE_CODE_LOCK: begin
        s.lamps.denied = 1'b1;
        s.lamps.locked = 1'b1;
      end
      MODE_CODE_UNLOCK: begin
        s.lamps.open = 1'b1;
        s.lamps.allow = 1'b1;
        s.lamps.unlocked = 1'b1;
      end
      MODE_CODE_EMG_WAIT: begin
        tens = hund_left / 7'd10;
        s.lamps.buzz = tens[0];
        s.lamps.open = tens[0];
        s.lamps.allow = tens[0];
        s.lamps.locked = 1'b1;
      end
      MODE_CODE_EMG_OPEN: begin
        s.lamps.open = 1'b1;
        s.lamps.fail = 1'b1;
        s.lamps.allow = 1'b1;
        s.lamps.unlocked = 1'b1;
      end
      default: begin
        s.lamps.open = 1'b1;
        s.lamps.unlocked = 1'b1;
      end
    endcase
    return s;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SECS_W-1:0] pick_secs();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 6'd63;
    if (r < 5) return 6'($urandom_range(2, 3));
    return 6'($urandom_range(0, 1));
  endfunction

  task automatic post_event(input logic [1:0] f, input logic [3:0] k,
                            input logic known, input door_status_t typed);
    door_status_t want;
    int unsigned  gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      event_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_ch.valid <= 1'b1;
    event_ch.func <= f;
    event_ch.key_code <= k;
    do @(posedge clk); while (!event_ch.ready);
    want = door_next_status(f, k);
    pending_status.push_back(known ? typed : want);
    events_sent++;
  endtask

  task automatic settle();
    event_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ACCESS_CODE:   code_reg = val;
      CFG_CODE_ARMED:    armed_reg = val[0];
      CFG_STRICT_MODE:   strict_reg = val[0];
      CFG_REQUEST_SECS:  request_reg = val[SECS_W-1:0];
      CFG_LOCK_SECS:     lock_reg = val[SECS_W-1:0];
      CFG_UNLOCK_SECS:   unlock_reg = val[SECS_W-1:0];
      CFG_EMG_WAIT_SECS: emg_wait_reg = val[SECS_W-1:0];
      default:           emg_open_reg = val[SECS_W-1:0];
    endcase
  endtask

  task automatic program_door(input logic [15:0] code, input logic armed, input logic strict,
                              input logic [SECS_W-1:0] req, input logic [SECS_W-1:0] lck,
                              input logic [SECS_W-1:0] unl, input logic [SECS_W-1:0] emg_w,
                              input logic [SECS_W-1:0] emg_o);
    settle();
    write_reg(CFG_ACCESS_CODE, code);
    write_reg(CFG_CODE_ARMED, CFG_DATA_W'(armed));
    write_reg(CFG_STRICT_MODE, CFG_DATA_W'(strict));
    write_reg(CFG_REQUEST_SECS, CFG_DATA_W'(req));
    write_reg(CFG_LOCK_SECS, CFG_DATA_W'(lck));
    write_reg(CFG_UNLOCK_SECS, CFG_DATA_W'(unl));
    write_reg(CFG_EMG_WAIT_SECS, CFG_DATA_W'(emg_w));
    write_reg(CFG_EMG_OPEN_SECS, CFG_DATA_W'(emg_o));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drive_random_burst();
    int unsigned r;
    int unsigned n;
    int          i;
    logic [3:0]  d;
    r = $urandom_range(0, 99);
    if (door_mode == MODE_CODE_NORMAL && r < 55) begin
      if ($urandom_range(0, 4) != 0) post_event(FUNC_KEY, KEY_STAR, 1'b0, NOT_TYPED);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : CODE_DIGITS;
      for (i = 0; i < int'(n); i++) begin
        d = code_reg[4*(CODE_DIGITS-1-(i % CODE_DIGITS)) +: 4];
        if (d > KEY_DIGIT_MAX || $urandom_range(0, 7) == 0) d = 4'($urandom_range(0, 9));
        post_event(FUNC_KEY, d, 1'b0, NOT_TYPED);
      end
      post_event(FUNC_KEY, ($urandom_range(0, 9) == 0) ? KEY_STAR : KEY_HASH,
                 1'b0, NOT_TYPED);
    end else if ((door_mode != MODE_CODE_NORMAL && r < 80) || r < 75) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      repeat (n) post_event(FUNC_TICK, 4'($urandom_range(0, 15)), 1'b0, NOT_TYPED);
    end else if (r < 90) begin
      post_event(($urandom_range(0, 1) == 0) ? FUNC_UNLOCK : FUNC_LOCK,
                 4'($urandom_range(0, 15)), 1'b0, NOT_TYPED);
    end else begin
      post_event(FUNC_KEY, 4'($urandom_range(0, 15)), 1'b0, NOT_TYPED);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      status_ch.ready <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      rx_hold <= pick_gap();
      status_ch.ready <= 1'b0;
    end else begin
      status_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : status_monitor
    door_status_t want;
    if (!rst && status_ch.valid && status_ch.ready) begin
      if (pending_status.size() == 0) begin
        $error("status beat with no event outstanding");
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("mode", want.mode, status_ch.mode);
        check_field("lamp_open", want.lamps.open, status_ch.lamp_open);
        check_field("lamp_fail", want.lamps.fail, status_ch.lamp_fail);
        check_field("lamp_allow", want.lamps.allow, status_ch.lamp_allow);
        check_field("lamp_denied", want.lamps.denied, status_ch.lamp_denied);
        check_field("lamp_locked", want.lamps.locked, status_ch.lamp_locked);
        check_field("lamp_unlocked", want.lamps.unlocked, status_ch.lamp_unlocked);
        check_field("buzz", want.lamps.buzz, status_ch.buzz);
        check_field("seconds_left", want.secs, status_ch.seconds_left);
        check_field("hundredths_left", want.hund, status_ch.hundredths_left);
      end
    end
  end

  initial begin : stimulus
    int          row;
    int unsigned phase_no;
    int unsigned phase_end;
    logic [15:0] code;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    event_ch.valid <= 1'b0;
    event_ch.func <= FUNC_TICK;
    event_ch.key_code <= '0;

    door_mode = MODE_CODE_NORMAL;
    secs_left = '0;
    hund_left = '0;
    entry_digits = {CODE_DIGITS{RST_DIGIT}};
    entry_pos = 3'd0;
    code_reg = '0;
    armed_reg = 1'b0;
    strict_reg = 1'b0;
    request_reg = RST_REQUEST_SECS;
    lock_reg = RST_LOCK_SECS;
    unlock_reg = RST_UNLOCK_SECS;
    emg_wait_reg = RST_EMG_WAIT_SECS;
    emg_open_reg = RST_EMG_OPEN_SECS;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < SCRIPT_LEN; row++) begin
      if (row == PHASE_B_ROW)
        program_door(16'h0000, 1'b1, 1'b1, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0);
      if (row == PHASE_C_ROW)
        program_door(16'h0000, 1'b1, 1'b0, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0);
      post_event(script[row].func, script[row].key, script[row].known, script[row].want);
    end

    phase_no = 0;
    while (events_sent < TOTAL_EVENTS) begin
      if (phase_no == 0) begin
        program_door(16'hFFFF, 1'b1, 1'b0, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63);
      end else begin
        if ($urandom_range(0, 3) == 0)
          code = 16'($urandom_range(0, 65535));
        else
          code = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                  4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        program_door(code, phase_no != 1 && $urandom_range(0, 6) != 0,
                     $urandom_range(0, 6) == 0,
                     pick_secs(), pick_secs(), pick_secs(), pick_secs(), pick_secs());
      end
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      phase_end = events_sent + $urandom_range(60, 140);
      while (events_sent < phase_end && events_sent < TOTAL_EVENTS)
        drive_random_burst();
      phase_no++;
    end

    event_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
